FILE: design/pwmds_pkg.sv
package pwmds_pkg;

	// input beat: one command
	typedef struct packed {
		logic        cmd;
		logic [3:0]  timer_index;
		logic [7:0]  pin_code;
		logic [15:0] frequency;
		logic [17:0] duty_fraction;
	} pwmds_in_t;

	// output beat: one result
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] top_value;
		logic [2:0]  prescaler_code;
		logic [15:0] compare_value;
		logic [1:0]  compare_channel;
	} pwmds_out_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_SCALE,
		S_MUL,
		S_CLAMP,
		S_DONE
	} pwmds_state_t;

	// command codes
	localparam logic CMD_FREQ = 1'b0;
	localparam logic CMD_DUTY = 1'b1;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_RANGE     = 3'd1;
	localparam logic [2:0] ST_ABSENT    = 3'd2;
	localparam logic [2:0] ST_CHANNEL   = 3'd3;
	localparam logic [2:0] ST_ZERO_FREQ = 3'd4;

	// existing timers
	localparam logic [3:0] TIMER_ONE   = 4'd1;
	localparam logic [3:0] TIMER_THREE = 4'd3;
	localparam logic [3:0] TIMER_FOUR  = 4'd4;
	localparam logic [3:0] TIMER_FIVE  = 4'd5;

	// channel nibble codes
	localparam logic [3:0] CHANNEL_BASE = 4'hA;
	localparam logic [3:0] CHANNEL_B    = 4'hB;
	localparam logic [3:0] CHANNEL_C    = 4'hC;

	// clock select codes
	localparam logic [2:0] PRE_DIV1 = 3'd1;
	localparam logic [2:0] PRE_NONE = 3'd0;

	// arithmetic constants
	localparam logic [24:0] CLOCK_RESET = 25'd16000000;
	localparam logic [23:0] TOP_LIMIT   = 24'd65536;
	localparam logic [15:0] TOP_SAT     = 16'hFFFF;
	localparam logic [4:0]  DIV_LAST    = 5'd24;
	localparam logic [4:0]  MUL_LAST    = 5'd17;
	localparam logic [2:0]  SCALE_STEPS = 3'd4;
	localparam int          ALU_W       = 34;

endpackage

FILE: design/pwm_period_and_duty_setup.sv
// frequency command: restoring division, then the prescaler steps, then the report; duty
// command: shift-add multiply, a clamp step, then the report; a rejected command goes
// straight to the report
// one item at a time through a single shared add/subtract unit; ready only when idle, so the
// next beat is taken in the cycle after the result is issued, later while the output stalls
// arst_n clears the sequencer, output valid, all stored tops to zero and clock_hz to 16000000
module pwm_period_and_duty_setup #(
	parameter int TIMER_SLOTS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  pwmds_pkg::pwmds_in_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pwmds_pkg::pwmds_out_t  out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [24:0]            cfg_data
);
	import pwmds_pkg::*;

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

	pwmds_state_t state_q, state_d;

	logic [24:0]      clock_hz_q;
	logic [15:0]      timer_top_q [TIMER_SLOTS];
	logic             out_valid_q;
	pwmds_out_t       out_q;
	pwmds_out_t       res_q;

	logic [IDX_W-1:0] tidx_q;
	logic [1:0]       chan_q;
	logic [15:0]      freq_q;
	logic [17:0]      duty_q;
	logic [15:0]      top_q;
	logic [15:0]      rem_q;
	logic [24:0]      quo_q;
	logic [4:0]       cnt_q;
	logic [23:0]      count_q;
	logic [2:0]       code_q;
	logic [2:0]       step_q;
	logic [ALU_W-1:0] acc_q;

	logic             in_acc;
	logic             out_free;
	logic [3:0]       tsel;
	logic             in_range;
	logic             present;
	logic             chan_ok;
	logic [2:0]       err_status;
	logic [16:0]      rem_sh;
	logic [ALU_W-1:0] alu_a, alu_b;
	logic             alu_sub;
	logic [ALU_W:0]   alu_res;
	logic             borrow;
	logic             scale_done;
	logic [15:0]      top_calc;
	logic [15:0]      cmp_calc;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// command checks on the incoming beat
	always_comb begin
		tsel     = (in_data.cmd == CMD_DUTY) ? in_data.pin_code[7:4] : in_data.timer_index;
		in_range = ({1'b0, tsel} < 5'(TIMER_SLOTS));
		present  = in_range && (tsel == TIMER_ONE || tsel == TIMER_THREE ||
			tsel == TIMER_FOUR || tsel == TIMER_FIVE);
		chan_ok  = (in_data.pin_code[3:0] == CHANNEL_BASE) ||
			(in_data.pin_code[3:0] == CHANNEL_B) || (in_data.pin_code[3:0] == CHANNEL_C);
		priority if (!in_range) begin
			err_status = ST_RANGE;
		end else if (!present) begin
			err_status = ST_ABSENT;
		end else if (in_data.cmd == CMD_FREQ && in_data.frequency == 16'd0) begin
			err_status = ST_ZERO_FREQ;
		end else if (in_data.cmd == CMD_DUTY && !chan_ok) begin
			err_status = ST_CHANNEL;
		end else begin
			err_status = ST_OK;
		end
	end

	// shared add/subtract unit
	assign rem_sh = {rem_q, quo_q[24]};
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_DIV: begin
				alu_a   = ALU_W'(rem_sh);
				alu_b   = ALU_W'(freq_q);
				alu_sub = 1'b1;
			end
			S_SCALE: begin
				alu_a   = ALU_W'(TOP_LIMIT);
				alu_b   = ALU_W'(count_q);
				alu_sub = 1'b1;
			end
			S_MUL: begin
				alu_a   = {acc_q[ALU_W-2:0], 1'b0};
				alu_b   = duty_q[17] ? ALU_W'(top_q) : '0;
			end
			S_CLAMP: begin
				alu_a   = ALU_W'(top_q);
				alu_b   = ALU_W'(acc_q[ALU_W-1:16]);
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
		alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
	end
	assign borrow = alu_res[ALU_W];

	// prescaler end condition and top, compare results
	always_comb begin
		scale_done = !borrow || (step_q == SCALE_STEPS);
		priority if (borrow) begin
			top_calc = TOP_SAT;
		end else if (count_q == 24'd0) begin
			top_calc = 16'd0;
		end else begin
			top_calc = 16'(count_q - 24'd1);
		end
		cmp_calc = borrow ? top_q : acc_q[31:16];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (err_status != ST_OK) begin
						state_d = S_DONE;
					end else if (in_data.cmd == CMD_FREQ) begin
						state_d = S_DIV;
					end else begin
						state_d = S_MUL;
					end
				end
			end
			S_DIV: begin
				if (cnt_q == DIV_LAST) state_d = S_SCALE;
			end
			S_SCALE: begin
				if (scale_done) state_d = S_DONE;
			end
			S_MUL: begin
				if (cnt_q == MUL_LAST) state_d = S_CLAMP;
			end
			S_CLAMP: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state: config, stored tops, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q  <= CLOCK_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				timer_top_q[i] <= 16'd0;
			end
		end else begin
			if (cfg_valid && cfg_ready) clock_hz_q <= cfg_data;
			if (state_q == S_SCALE && scale_done) timer_top_q[tidx_q] <= top_calc;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					tidx_q  <= tsel[IDX_W-1:0];
					chan_q  <= 2'(in_data.pin_code[3:0] - CHANNEL_BASE);
					freq_q  <= in_data.frequency;
					duty_q  <= in_data.duty_fraction;
					top_q   <= timer_top_q[tsel[IDX_W-1:0]];
					rem_q   <= 16'd0;
					quo_q   <= clock_hz_q;
					cnt_q   <= 5'd0;
					code_q  <= PRE_DIV1;
					step_q  <= 3'd0;
					acc_q   <= '0;
					res_q   <= {err_status, 16'd0, PRE_NONE, 16'd0, 2'd0};
				end
			end
			S_DIV: begin
				rem_q <= borrow ? rem_sh[15:0] : alu_res[15:0];
				quo_q <= {quo_q[23:0], !borrow};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == DIV_LAST) count_q <= quo_q[23:0];
			end
			S_SCALE: begin
				if (scale_done) begin
					res_q.top_value      <= top_calc;
					res_q.prescaler_code <= code_q;
				end else begin
					count_q <= (step_q < 3'd2) ? (count_q >> 3) : (count_q >> 2);
					code_q  <= code_q + 3'd1;
					step_q  <= step_q + 3'd1;
				end
			end
			S_MUL: begin
				acc_q  <= alu_res[ALU_W-1:0];
				duty_q <= {duty_q[16:0], 1'b0};
				cnt_q  <= cnt_q + 5'd1;
			end
			S_CLAMP: begin
				res_q.compare_value   <= cmp_calc;
				res_q.compare_channel <= chan_q;
				res_q.prescaler_code  <= PRE_NONE;
			end
			S_DONE: begin
				if (out_free) out_q <= res_q;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

endmodule

FILE: tb/pwmds_result_checker.sv
`timescale 1ns / 1ps

module pwmds_result_checker #(
	parameter int TIMER_SLOTS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  pwmds_pkg::pwmds_in_t   in_data,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  pwmds_pkg::pwmds_out_t  out_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [24:0]            cfg_data,
	output int                     fail_count,
	output int                     pending_count
);

	import pwmds_pkg::*;

	// shadow copy of the block's register and stored tops
	logic [24:0] clock_hz_q;
	logic [15:0] stored_top [TIMER_SLOTS];
	pwmds_out_t  expected_results [$];
	int          report_count;

	initial begin
		fail_count = 0;
		report_count = 0;
		pending_count = 0;
	end

	// range first, then whether the timer exists at all
	function automatic logic [2:0] timer_status(logic [3:0] t);
		if (int'(t) >= TIMER_SLOTS)
			return ST_RANGE;
		if (t == TIMER_ONE || t == TIMER_THREE || t == TIMER_FOUR || t == TIMER_FIVE)
			return ST_OK;
		return ST_ABSENT;
	endfunction

	// expected result of one command, updating the stored tops on success
	function automatic pwmds_out_t predict_result(pwmds_in_t c);
		pwmds_out_t  r;
		logic [3:0]  t;
		logic [3:0]  nib;
		logic [31:0] count;
		logic [2:0]  code;
		logic [15:0] top;
		logic [33:0] product;
		r = '0;
		if (c.cmd == CMD_FREQ) begin
			r.status = timer_status(c.timer_index);
			if (r.status == ST_OK && c.frequency == 16'd0)
				r.status = ST_ZERO_FREQ;
			if (r.status != ST_OK)
				return r;
			count = (32'(clock_hz_q) / 32'(c.frequency)) / 32'd2;
			code = PRE_DIV1;
			// prescaler ladder: /8, /64, /256, /1024
			if (count > 32'(TOP_LIMIT)) begin
				code = code + 3'd1;
				count = count / 32'd8;
			end
			if (count > 32'(TOP_LIMIT)) begin
				code = code + 3'd1;
				count = count / 32'd8;
			end
			if (count > 32'(TOP_LIMIT)) begin
				code = code + 3'd1;
				count = count / 32'd4;
			end
			if (count > 32'(TOP_LIMIT)) begin
				code = code + 3'd1;
				count = count / 32'd4;
			end
			if (count > 32'(TOP_LIMIT))
				top = TOP_SAT;
			else if (count == 32'd0)
				top = '0;
			else
				top = 16'(count - 32'd1);
			stored_top[c.timer_index] = top;
			r.top_value = top;
			r.prescaler_code = code;
		end else begin
			t = c.pin_code[7:4];
			nib = c.pin_code[3:0];
			r.status = timer_status(t);
			if (r.status == ST_OK && (nib < CHANNEL_BASE || nib > CHANNEL_C))
				r.status = ST_CHANNEL;
			if (r.status != ST_OK)
				return r;
			top = stored_top[t];
			// fixed-point product, truncated, clamped to the stored top
			product = (34'(top) * 34'(c.duty_fraction)) >> 16;
			r.compare_value = (product > 34'(top)) ? top : product[15:0];
			r.compare_channel = 2'(nib - CHANNEL_BASE);
		end
		return r;
	endfunction

	// result beats are matched before the new command beat is queued
	always @(posedge clk or negedge arst_n) begin
		pwmds_out_t want;
		if (!arst_n) begin
			clock_hz_q = CLOCK_RESET;
			foreach (stored_top[i])
				stored_top[i] = '0;
			expected_results.delete();
			pending_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (report_count < 10)
						$display("unexpected result beat at %0t: status %0d top %0d code %0d cmp %0d ch %0d",
							$time, out_data.status, out_data.top_value,
							out_data.prescaler_code, out_data.compare_value,
							out_data.compare_channel);
					report_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_data !== want) begin
						fail_count++;
						if (report_count < 10) begin
							$write("mismatch at %0t (expected/actual): status %0d/%0d top %0d/%0d",
								$time, want.status, out_data.status,
								want.top_value, out_data.top_value);
							$display(" code %0d/%0d cmp %0d/%0d ch %0d/%0d",
								want.prescaler_code, out_data.prescaler_code,
								want.compare_value, out_data.compare_value,
								want.compare_channel, out_data.compare_channel);
						end
						report_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				clock_hz_q = cfg_data;
			if (in_valid && in_ready)
				expected_results.push_back(predict_result(in_data));
			pending_count = expected_results.size();
		end
	end

endmodule

FILE: tb/pwm_period_and_duty_setup_tb.sv
`timescale 1ns / 1ps

module pwm_period_and_duty_setup_tb;

	import pwmds_pkg::*;

	localparam int          SLOTS        = 6;
	localparam int          DRAIN_CYCLES = 40;
	localparam int          RANDOM_ITEMS = 240;
	localparam int          PHASES       = 8;
	localparam logic [24:0] CLOCK_MAX    = 25'h1FFFFFF;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	pwmds_in_t   in_data;
	logic        out_valid;
	logic        out_ready;
	pwmds_out_t  out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [24:0] cfg_data;
	int          fail_count;
	int          pending_count;
	bit          send_burst;
	bit          recv_burst;

	pwm_period_and_duty_setup #(
		.TIMER_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	pwmds_result_checker #(
		.TIMER_SLOTS(SLOTS)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending_count(pending_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [3:0] real_timer();
		case ($urandom_range(0, 3))
			0: return TIMER_ONE;
			1: return TIMER_THREE;
			2: return TIMER_FOUR;
			default: return TIMER_FIVE;
		endcase
	endfunction

	// unused fields carry noise so every bit toggles
	function automatic pwmds_in_t freq_cmd(logic [3:0] t, logic [15:0] f);
		pwmds_in_t c;
		c.cmd = CMD_FREQ;
		c.timer_index = t;
		c.pin_code = 8'($urandom);
		c.frequency = f;
		c.duty_fraction = 18'($urandom);
		return c;
	endfunction

	function automatic pwmds_in_t duty_cmd(logic [7:0] pin, logic [17:0] duty);
		pwmds_in_t c;
		c.cmd = CMD_DUTY;
		c.timer_index = 4'($urandom);
		c.pin_code = pin;
		c.frequency = 16'($urandom);
		c.duty_fraction = duty;
		return c;
	endfunction

	// mostly well-formed commands, some raw noise
	function automatic pwmds_in_t random_cmd();
		pwmds_in_t c;
		int        w;
		c.cmd = 1'($urandom);
		c.timer_index = 4'($urandom);
		c.pin_code = 8'($urandom);
		c.frequency = 16'($urandom);
		c.duty_fraction = 18'($urandom);
		if ($urandom_range(0, 99) < 8)
			return c;
		if (c.cmd == CMD_FREQ) begin
			if ($urandom_range(0, 99) < 85)
				c.timer_index = real_timer();
			// spread magnitudes so every prescaler step is hit; width zero gives zero
			w = $urandom_range(0, 16);
			c.frequency = 16'($urandom & ((32'd1 << w) - 32'd1));
		end else begin
			if ($urandom_range(0, 99) < 85)
				c.pin_code[7:4] = real_timer();
			if ($urandom_range(0, 99) < 85)
				c.pin_code[3:0] = CHANNEL_BASE + 4'($urandom_range(0, 2));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: c.duty_fraction = 18'($urandom_range(0, 65536));
				6, 7, 8: c.duty_fraction = 18'($urandom);
				default: begin
					case ($urandom_range(0, 2))
						0: c.duty_fraction = '0;
						1: c.duty_fraction = 18'd65536;
						default: c.duty_fraction = '1;
					endcase
				end
			endcase
		end
		return c;
	endfunction

	// called and returns at a falling edge
	task automatic send_cmd(input pwmds_in_t c);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= c;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// hold off until every result has come back and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_clock(input logic [24:0] value);
		drain();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls with stretches of constant ready
	initial begin
		int gap;
		out_ready = 1'b0;
		recv_burst = 1'b0;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_burst = !recv_burst;
			gap = recv_burst ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	// command side and verdict
	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		send_burst = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: status order, extremes, channel decoding at the reset clock
		send_cmd(freq_cmd(4'd0, 16'd1000));
		send_cmd(freq_cmd(4'd15, 16'd1000));
		send_cmd(freq_cmd(4'd6, 16'd1000));
		send_cmd(freq_cmd(4'd2, 16'd0));
		send_cmd(freq_cmd(TIMER_ONE, 16'd0));
		send_cmd(duty_cmd({TIMER_THREE, CHANNEL_BASE}, 18'd32768));
		send_cmd(freq_cmd(TIMER_ONE, 16'd1));
		send_cmd(freq_cmd(TIMER_THREE, 16'hFFFF));
		send_cmd(freq_cmd(TIMER_FOUR, 16'd500));
		send_cmd(freq_cmd(TIMER_FIVE, 16'd30));
		send_cmd(duty_cmd({TIMER_ONE, CHANNEL_BASE}, 18'd0));
		send_cmd(duty_cmd({TIMER_THREE, CHANNEL_B}, 18'd65536));
		send_cmd(duty_cmd({TIMER_FOUR, CHANNEL_C}, 18'h3FFFF));
		send_cmd(duty_cmd({TIMER_FIVE, CHANNEL_BASE}, 18'd32768));
		send_cmd(duty_cmd({TIMER_FIVE, 4'hD}, 18'd1000));
		send_cmd(duty_cmd({TIMER_FIVE, 4'h9}, 18'd1000));
		send_cmd(duty_cmd(8'h20, 18'd1000));
		send_cmd(duty_cmd(8'hFF, 18'd1000));
		send_cmd(duty_cmd({4'd6, CHANNEL_BASE}, 18'd1000));
		send_cmd(duty_cmd({4'd0, CHANNEL_C}, 18'd1000));

		// fastest clock: the /256 prescaler step
		write_clock(CLOCK_MAX);
		send_cmd(freq_cmd(TIMER_ONE, 16'd1));
		send_cmd(duty_cmd({TIMER_ONE, CHANNEL_B}, 18'hFFFF));

		// slowest clock: count falls to zero
		write_clock(25'd1);
		send_cmd(freq_cmd(TIMER_THREE, 16'd1));
		send_cmd(duty_cmd({TIMER_THREE, CHANNEL_C}, 18'h3FFFF));

		// random phases over a spread of clock settings
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: ;
				1: write_clock(CLOCK_MAX);
				2: write_clock(25'd1);
				3: write_clock(25'($urandom_range(1, 100000)));
				4: write_clock(CLOCK_RESET);
				default: write_clock(25'($urandom_range(1, 33554431)));
			endcase
			for (int n = 0; n < RANDOM_ITEMS; n++) begin
				if ($urandom_range(0, 149) == 0)
					drain();
				send_cmd(random_cmd());
			end
		end

		drain();
		if (fail_count == 0 && pending_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: pwm_period_and_duty_setup.f
design/pwmds_pkg.sv
design/pwm_period_and_duty_setup.sv
tb/pwmds_result_checker.sv
tb/pwm_period_and_duty_setup_tb.sv
